/* hdl/udp_ipv4_header_parser_defines.svh */
// Assertion macros shared by the header parser modules.
// No dependencies; included inside module bodies that check their own logic.
`ifndef UDP_IPV4_HEADER_PARSER_DEFINES_SVH
`define UDP_IPV4_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UHP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("header parser check failed");

// Next-cycle implication, disabled during reset.
`define UHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("header parser check failed");

`endif

/* hdl/udp_hp_pkg.sv */
// Types and constants for the UDP/IPv4 header parser.
// No dependencies; imported by the front, queue, back and top modules.
package udp_hp_pkg;

  // Width of the clamped frame size carried from front to back
  localparam int SIZE_W = 17;

  localparam logic [15:0] LINK_TYPE_ETH  = 16'h0001;
  localparam logic [15:0] TPID_8021Q     = 16'h8100;
  localparam logic [15:0] TPID_8021AD    = 16'h88A8;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] FRAG_OFS_MASK  = 16'h1FFF;
  localparam logic [15:0] FLAG_MF        = 16'h2000;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [4:0]  ETH_HDR_LEN    = 5'd14;
  localparam logic [4:0]  VLAN_HDR_LEN   = 5'd18;
  localparam logic [6:0]  IP_MIN_HDR     = 7'd20;
  localparam logic [6:0]  UDP_HDR_LEN    = 7'd8;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;

  typedef enum logic [3:0] {
    ERR_OK            = 4'd0,
    ERR_LINK          = 4'd1,
    ERR_SHORT_ETH     = 4'd2,
    ERR_SHORT_VLAN    = 4'd3,
    ERR_NOT_IPV4      = 4'd4,
    ERR_SHORT_IP      = 4'd5,
    ERR_VERSION       = 4'd6,
    ERR_IHL           = 4'd7,
    ERR_IP_HDR_TRUNC  = 4'd8,
    ERR_TOTAL_LEN     = 4'd9,
    ERR_IP_TRUNC      = 4'd10,
    ERR_FRAGMENT      = 4'd11,
    ERR_NOT_UDP       = 4'd12,
    ERR_UDP_HDR_TRUNC = 4'd13,
    ERR_UDP_LEN       = 4'd14,
    ERR_PAYLOAD_TRUNC = 4'd15
  } err_code_t;

  // Captured header fields of one finished frame
  typedef struct packed {
    logic [15:0]       link_kind;
    logic [15:0]       outer_type;
    logic [15:0]       inner_type;
    logic [7:0]        version_ihl;
    logic [15:0]       total_length;
    logic [15:0]       flags_fragment;
    logic [7:0]        protocol;
    logic [31:0]       src_addr;
    logic [31:0]       dst_addr;
    logic [15:0]       src_port;
    logic [15:0]       dst_port;
    logic [15:0]       udp_length;
    logic [SIZE_W-1:0] frame_size;
  } hdr_rec_t;

endpackage

/* hdl/udp_hp_front.sv */
// Front end: counts frame bytes and captures header fields at their offsets.
// Depends on udp_hp_pkg; pushes one hdr_rec_t per frame into the queue.
module udp_hp_front #(
  parameter int COUNT_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           frame_byte,
  input  logic [15:0]          link_kind,
  input  logic                 last_byte,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic                 queue_full,
  output logic                 push,
  output udp_hp_pkg::hdr_rec_t push_rec
);
  import udp_hp_pkg::*;

  `include "udp_ipv4_header_parser_defines.svh"

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_index, byte_index_next;
  logic [15:0] held_link_kind, held_link_kind_next;
  logic [15:0] outer_type, outer_type_next;
  logic [15:0] inner_type, inner_type_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] flags_fragment, flags_fragment_next;
  logic [7:0]  protocol, protocol_next;
  logic [31:0] src_addr, src_addr_next;
  logic [31:0] dst_addr, dst_addr_next;
  logic [15:0] src_port, src_port_next;
  logic [15:0] dst_port, dst_port_next;
  logic [15:0] udp_length, udp_length_next;

  logic                  accept;
  logic                  has_tag;
  logic [COUNT_BITS-1:0] p;
  logic [COUNT_BITS-1:0] net_pos;
  logic [COUNT_BITS-1:0] udp_pos;
  logic [SIZE_W-1:0]     size_clamped;

  assign byte_stall = queue_full;
  assign accept     = byte_valid & ~byte_stall;
  assign p          = byte_index;

  // Locate network and transport headers from what is captured so far
  assign has_tag = (outer_type == TPID_8021Q) || (outer_type == TPID_8021AD);
  assign net_pos = has_tag ? COUNT_BITS'(VLAN_HDR_LEN) : COUNT_BITS'(ETH_HDR_LEN);
  assign udp_pos = net_pos + COUNT_BITS'({version_ihl[3:0], 2'b00});

  // Shift each field in at its byte offset
  always_comb begin
    held_link_kind_next = held_link_kind;
    outer_type_next     = outer_type;
    inner_type_next     = inner_type;
    version_ihl_next    = version_ihl;
    total_length_next   = total_length;
    flags_fragment_next = flags_fragment;
    protocol_next       = protocol;
    src_addr_next       = src_addr;
    dst_addr_next       = dst_addr;
    src_port_next       = src_port;
    dst_port_next       = dst_port;
    udp_length_next     = udp_length;

    if (p == '0) begin
      held_link_kind_next = link_kind;
    end
    if (p == COUNT_BITS'(12) || p == COUNT_BITS'(13)) begin
      outer_type_next = {outer_type[7:0], frame_byte};
    end
    if (p == COUNT_BITS'(16) || p == COUNT_BITS'(17)) begin
      inner_type_next = {inner_type[7:0], frame_byte};
    end
    if (p == net_pos) begin
      version_ihl_next = frame_byte;
    end
    if (p == net_pos + COUNT_BITS'(2) || p == net_pos + COUNT_BITS'(3)) begin
      total_length_next = {total_length[7:0], frame_byte};
    end
    if (p == net_pos + COUNT_BITS'(6) || p == net_pos + COUNT_BITS'(7)) begin
      flags_fragment_next = {flags_fragment[7:0], frame_byte};
    end
    if (p == net_pos + COUNT_BITS'(9)) begin
      protocol_next = frame_byte;
    end
    if (p >= net_pos + COUNT_BITS'(12) && p <= net_pos + COUNT_BITS'(15)) begin
      src_addr_next = {src_addr[23:0], frame_byte};
    end
    if (p >= net_pos + COUNT_BITS'(16) && p <= net_pos + COUNT_BITS'(19)) begin
      dst_addr_next = {dst_addr[23:0], frame_byte};
    end
    if (p > net_pos) begin
      if (p == udp_pos || p == udp_pos + COUNT_BITS'(1)) begin
        src_port_next = {src_port[7:0], frame_byte};
      end
      if (p == udp_pos + COUNT_BITS'(2) || p == udp_pos + COUNT_BITS'(3)) begin
        dst_port_next = {dst_port[7:0], frame_byte};
      end
      if (p == udp_pos + COUNT_BITS'(4) || p == udp_pos + COUNT_BITS'(5)) begin
        udp_length_next = {udp_length[7:0], frame_byte};
      end
    end
  end

  // Saturating byte count, then clamp it to the width the checks need
  assign byte_index_next = (p == COUNT_MAX) ? p : p + COUNT_BITS'(1);
  assign size_clamped    = (|(byte_index_next >> SIZE_W)) ? {SIZE_W{1'b1}}
                                                          : byte_index_next[SIZE_W-1:0];

  // Hand the finished header to the back end on the last byte
  assign push = accept & last_byte;
  always_comb begin
    push_rec.link_kind      = held_link_kind_next;
    push_rec.outer_type     = outer_type_next;
    push_rec.inner_type     = inner_type_next;
    push_rec.version_ihl    = version_ihl_next;
    push_rec.total_length   = total_length_next;
    push_rec.flags_fragment = flags_fragment_next;
    push_rec.protocol       = protocol_next;
    push_rec.src_addr       = src_addr_next;
    push_rec.dst_addr       = dst_addr_next;
    push_rec.src_port       = src_port_next;
    push_rec.dst_port       = dst_port_next;
    push_rec.udp_length     = udp_length_next;
    push_rec.frame_size     = size_clamped;
  end

  // Advance on each accepted request; clear everything at the end of a frame
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_index     <= '0;
      held_link_kind <= '0;
      outer_type     <= '0;
      inner_type     <= '0;
      version_ihl    <= '0;
      total_length   <= '0;
      flags_fragment <= '0;
      protocol       <= '0;
      src_addr       <= '0;
      dst_addr       <= '0;
      src_port       <= '0;
      dst_port       <= '0;
      udp_length     <= '0;
    end else if (accept) begin
      byte_index     <= byte_index_next;
      held_link_kind <= held_link_kind_next;
      outer_type     <= outer_type_next;
      inner_type     <= inner_type_next;
      version_ihl    <= version_ihl_next;
      total_length   <= total_length_next;
      flags_fragment <= flags_fragment_next;
      protocol       <= protocol_next;
      src_addr       <= src_addr_next;
      dst_addr       <= dst_addr_next;
      src_port       <= src_port_next;
      dst_port       <= dst_port_next;
      udp_length     <= udp_length_next;
    end
  end

  `UHP_ASSERT_NEXT(a_count_clears_at_end, clk, rst, push, byte_index == '0)
  `UHP_ASSERT_NEXT(a_count_advances, clk, rst,
                   accept && !last_byte && byte_index != COUNT_MAX,
                   byte_index == $past(byte_index) + COUNT_BITS'(1))

endmodule

/* hdl/udp_hp_queue.sv */
// Two-entry queue of captured headers between front and back ends.
// Depends on udp_hp_pkg for hdr_rec_t.
module udp_hp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  udp_hp_pkg::hdr_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output udp_hp_pkg::hdr_rec_t head_rec
);
  import udp_hp_pkg::*;

  `include "udp_ipv4_header_parser_defines.svh"

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  hdr_rec_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == (PTR_W + 1)'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign head_rec  = entries[rd_ptr];

  // Store payload without reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  `UHP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= (PTR_W + 1)'(DEPTH))
  `UHP_ASSERT_NEXT(a_count_grows, clk, rst, do_push && !do_pop,
                   count == $past(count) + (PTR_W + 1)'(1))

endmodule

/* hdl/udp_hp_back.sv */
// Back end: runs the ordered header checks and holds the result register.
// Depends on udp_hp_pkg; pops one hdr_rec_t per result.
module udp_hp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  udp_hp_pkg::hdr_rec_t rec,
  output logic                 rec_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 packet_ok,
  output logic [3:0]           error_code,
  output logic [31:0]          source_address,
  output logic [31:0]          dest_address,
  output logic [15:0]          source_port,
  output logic [15:0]          dest_port,
  output logic [6:0]           payload_start,
  output logic [15:0]          payload_bytes
);
  import udp_hp_pkg::*;

  `include "udp_ipv4_header_parser_defines.svh"

  localparam int CW = SIZE_W + 1;

  logic        has_tag;
  logic [15:0] eth_type;
  logic [4:0]  net;
  logic [5:0]  hl;
  logic [6:0]  udp;
  logic [CW-1:0] size_w;
  logic [CW-1:0] ip_end;
  logic [CW-1:0] udp_end;
  err_code_t   code;
  logic        load;

  // Header geometry of the frame at the queue head
  assign has_tag  = (rec.outer_type == TPID_8021Q) || (rec.outer_type == TPID_8021AD);
  assign eth_type = has_tag ? rec.inner_type : rec.outer_type;
  assign net      = has_tag ? VLAN_HDR_LEN : ETH_HDR_LEN;
  assign hl       = {rec.version_ihl[3:0], 2'b00};
  assign udp      = 7'(net) + 7'(hl);
  assign size_w   = CW'(rec.frame_size);
  assign ip_end   = CW'(net) + CW'(rec.total_length);
  assign udp_end  = CW'(udp) + CW'(rec.udp_length);

  // Report the first failing check
  always_comb begin
    if (rec.link_kind != LINK_TYPE_ETH) begin
      code = ERR_LINK;
    end else if (size_w < CW'(ETH_HDR_LEN)) begin
      code = ERR_SHORT_ETH;
    end else if (has_tag && size_w < CW'(VLAN_HDR_LEN)) begin
      code = ERR_SHORT_VLAN;
    end else if (eth_type != ETHERTYPE_IPV4) begin
      code = ERR_NOT_IPV4;
    end else if (size_w < CW'(net) + CW'(IP_MIN_HDR)) begin
      code = ERR_SHORT_IP;
    end else if (rec.version_ihl[7:4] != IP_VERSION4) begin
      code = ERR_VERSION;
    end else if (7'(hl) < IP_MIN_HDR) begin
      code = ERR_IHL;
    end else if (size_w < CW'(udp)) begin
      code = ERR_IP_HDR_TRUNC;
    end else if (rec.total_length < 16'(7'(hl) + UDP_HDR_LEN)) begin
      code = ERR_TOTAL_LEN;
    end else if (size_w < ip_end) begin
      code = ERR_IP_TRUNC;
    end else if ((rec.flags_fragment & FRAG_OFS_MASK) != '0 ||
                 (rec.flags_fragment & FLAG_MF) != '0) begin
      code = ERR_FRAGMENT;
    end else if (rec.protocol != IP_PROTO_UDP) begin
      code = ERR_NOT_UDP;
    end else if (size_w < CW'(udp + UDP_HDR_LEN)) begin
      code = ERR_UDP_HDR_TRUNC;
    end else if (rec.udp_length < 16'(UDP_HDR_LEN)) begin
      code = ERR_UDP_LEN;
    end else if (udp_end > ip_end || udp_end > size_w) begin
      code = ERR_PAYLOAD_TRUNC;
    end else begin
      code = ERR_OK;
    end
  end

  // Load the result register when it is empty or being drained
  assign load    = rec_valid & (~result_valid | ~result_stall);
  assign rec_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Hold result payload; zero the fields a failing check leaves unproven
  always_ff @(posedge clk) begin
    if (load) begin
      packet_ok  <= (code == ERR_OK);
      error_code <= code;
      if (code == ERR_OK || code >= ERR_UDP_HDR_TRUNC) begin
        source_address <= rec.src_addr;
        dest_address   <= rec.dst_addr;
      end else begin
        source_address <= '0;
        dest_address   <= '0;
      end
      if (code == ERR_OK || code >= ERR_UDP_LEN) begin
        source_port <= rec.src_port;
        dest_port   <= rec.dst_port;
      end else begin
        source_port <= '0;
        dest_port   <= '0;
      end
      if (code == ERR_OK) begin
        payload_start <= udp + UDP_HDR_LEN;
        payload_bytes <= rec.udp_length - 16'(UDP_HDR_LEN);
      end else begin
        payload_start <= '0;
        payload_bytes <= '0;
      end
    end
  end

  `UHP_ASSERT_NOW(a_ok_matches_code, clk, rst, result_valid,
                  packet_ok == (error_code == ERR_OK))
  `UHP_ASSERT_NOW(a_fail_no_payload, clk, rst, result_valid && error_code != ERR_OK,
                  payload_start == '0 && payload_bytes == '0)

endmodule

/* hdl/udp_ipv4_header_parser.sv */
// Top level of the Ethernet/VLAN/IPv4/UDP header parser.
// Depends on udp_hp_pkg, udp_hp_front, udp_hp_queue and udp_hp_back.
//
// Usage:
//   Byte channel (frame_byte, link_kind, last_byte, byte_valid/byte_stall)
//   takes one frame byte per request, in wire order; link_kind is sampled on
//   the first byte of each frame and last_byte marks the final byte.
//   Result channel (result_valid/result_stall) returns one result per frame:
//   packet_ok, error_code and the address, port and payload fields.
//   Throughput: one byte every cycle while byte_stall is low; the front end
//   captures header fields as bytes stream past and stalls only on a full queue.
//   Result path: the last byte taken writes its header into the two-entry
//   queue, and the check stage loads the result register from the queue
//   head, which raises result_valid; a stalled result register delays it.
//   Stall: while result_stall is high the result holds; up to two further
//   finished frames wait in the queue, and byte_stall rises only when the
//   queue is full.
//   Reset: rst is synchronous; it clears the byte counter, captured fields,
//   queue and result valid, and the block takes bytes the next cycle.
module udp_ipv4_header_parser #(
  parameter int COUNT_BITS = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  frame_byte,
  input  logic [15:0] link_kind,
  input  logic        last_byte,
  input  logic        byte_valid,
  output logic        byte_stall,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        packet_ok,
  output logic [3:0]  error_code,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [6:0]  payload_start,
  output logic [15:0] payload_bytes
);
  import udp_hp_pkg::*;

  hdr_rec_t push_rec;
  hdr_rec_t head_rec;
  logic     push;
  logic     queue_full;
  logic     queue_not_empty;
  logic     pop;

  udp_hp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_byte (frame_byte),
    .link_kind  (link_kind),
    .last_byte  (last_byte),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  udp_hp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head_rec  (head_rec)
  );

  udp_hp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_valid      (queue_not_empty),
    .rec            (head_rec),
    .rec_pop        (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .packet_ok      (packet_ok),
    .error_code     (error_code),
    .source_address (source_address),
    .dest_address   (dest_address),
    .source_port    (source_port),
    .dest_port      (dest_port),
    .payload_start  (payload_start),
    .payload_bytes  (payload_bytes)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for udp_ipv4_header_parser: byte-stream frames in, one result per frame.
// Depends on udp_hp_pkg and the parser RTL; the expected results come from an in-file parser model.
module tb;
  import udp_hp_pkg::*;

  localparam int COUNT_BITS = 17;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1100;
  localparam int HOLD_START = 600;
  localparam int HOLD_CYCLES = 800;

  // One byte request on the input channel
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] link;
    logic        last;
  } byte_req_t;

  // One parse result as seen on the output channel
  typedef struct {
    logic        ok;
    err_code_t   code;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [6:0]  pstart;
    logic [15:0] plen;
  } parse_result_t;

  // Header contents used to build one frame
  typedef struct {
    logic [15:0] link;
    logic [15:0] outer;
    logic [15:0] inner;
    logic [7:0]  vihl;
    logic [15:0] total;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    int          flen;
  } frame_spec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  frame_byte = '0;
  logic [15:0] link_kind = '0;
  logic        last_byte = 1'b0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        packet_ok;
  logic [3:0]  error_code;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [6:0]  payload_start;
  logic [15:0] payload_bytes;

  udp_ipv4_header_parser #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk), .rst(rst),
    .frame_byte(frame_byte), .link_kind(link_kind), .last_byte(last_byte),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .result_valid(result_valid), .result_stall(result_stall),
    .packet_ok(packet_ok), .error_code(error_code),
    .source_address(source_address), .dest_address(dest_address),
    .source_port(source_port), .dest_port(dest_port),
    .payload_start(payload_start), .payload_bytes(payload_bytes)
  );

  byte_req_t     pending_bytes[$];
  parse_result_t expected_results[$];
  logic [7:0]    frame_buf[];

  int mismatches = 0;
  int results_checked = 0;
  int frames_queued = 0;
  int bytes_queued = 0;
  int longest_frame = 0;
  int cycle_count = 0;
  int code_hits[16];

  // Parser model state
  int unsigned pos_q = 0;
  logic [15:0] cap_link = '0;
  logic [15:0] cap_outer = '0;
  logic [15:0] cap_inner = '0;
  logic [7:0]  cap_vihl = '0;
  logic [15:0] cap_total = '0;
  logic [15:0] cap_frag = '0;
  logic [7:0]  cap_proto = '0;
  logic [31:0] cap_saddr = '0;
  logic [31:0] cap_daddr = '0;
  logic [15:0] cap_sport = '0;
  logic [15:0] cap_dport = '0;
  logic [15:0] cap_ulen = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic is_vlan_tpid(input logic [15:0] t);
    return t == TPID_8021Q || t == TPID_8021AD;
  endfunction

  // Advance the parser model by one accepted byte; on the last byte, queue its result
  task automatic predict_byte(input logic [7:0] b, input logic [15:0] lk, input logic lst);
    int unsigned p, net, hl, udp, sz;
    err_code_t code;
    parse_result_t r;
    p = pos_q;
    if (p == 0) cap_link = lk;
    if (p == 12 || p == 13) cap_outer = {cap_outer[7:0], b};
    if (p == 16 || p == 17) cap_inner = {cap_inner[7:0], b};
    if (p >= 14) begin
      net = is_vlan_tpid(cap_outer) ? int'(VLAN_HDR_LEN) : int'(ETH_HDR_LEN);
      hl = int'(cap_vihl[3:0]) * 4;
      udp = net + hl;
      if (p == net) cap_vihl = b;
      if (p == net + 2 || p == net + 3) cap_total = {cap_total[7:0], b};
      if (p == net + 6 || p == net + 7) cap_frag = {cap_frag[7:0], b};
      if (p == net + 9) cap_proto = b;
      if (p >= net + 12 && p <= net + 15) cap_saddr = {cap_saddr[23:0], b};
      if (p >= net + 16 && p <= net + 19) cap_daddr = {cap_daddr[23:0], b};
      if (p > net) begin
        if (p == udp || p == udp + 1) cap_sport = {cap_sport[7:0], b};
        if (p == udp + 2 || p == udp + 3) cap_dport = {cap_dport[7:0], b};
        if (p == udp + 4 || p == udp + 5) cap_ulen = {cap_ulen[7:0], b};
      end
    end
    // Saturate the byte count
    pos_q = (p >= COUNT_MAX) ? COUNT_MAX : p + 1;
    if (!lst) return;

    sz = pos_q;
    net = is_vlan_tpid(cap_outer) ? int'(VLAN_HDR_LEN) : int'(ETH_HDR_LEN);
    hl = int'(cap_vihl[3:0]) * 4;
    udp = net + hl;
    // Run the checks in order; the first failure wins
    if (cap_link != LINK_TYPE_ETH) code = ERR_LINK;
    else if (sz < ETH_HDR_LEN) code = ERR_SHORT_ETH;
    else if (is_vlan_tpid(cap_outer) && sz < VLAN_HDR_LEN) code = ERR_SHORT_VLAN;
    else if ((is_vlan_tpid(cap_outer) ? cap_inner : cap_outer) != ETHERTYPE_IPV4)
      code = ERR_NOT_IPV4;
    else if (sz < net + IP_MIN_HDR) code = ERR_SHORT_IP;
    else if (cap_vihl[7:4] != IP_VERSION4) code = ERR_VERSION;
    else if (hl < IP_MIN_HDR) code = ERR_IHL;
    else if (sz < net + hl) code = ERR_IP_HDR_TRUNC;
    else if (cap_total < hl + UDP_HDR_LEN) code = ERR_TOTAL_LEN;
    else if (sz < net + cap_total) code = ERR_IP_TRUNC;
    else if ((cap_frag & FRAG_OFS_MASK) != 0 || (cap_frag & FLAG_MF) != 0) code = ERR_FRAGMENT;
    else if (cap_proto != IP_PROTO_UDP) code = ERR_NOT_UDP;
    else if (sz < udp + UDP_HDR_LEN) code = ERR_UDP_HDR_TRUNC;
    else if (cap_ulen < UDP_HDR_LEN) code = ERR_UDP_LEN;
    else if (udp + cap_ulen > net + cap_total || udp + cap_ulen > sz) code = ERR_PAYLOAD_TRUNC;
    else code = ERR_OK;

    r.ok = (code == ERR_OK);
    r.code = code;
    r.saddr = (code == ERR_OK || code >= ERR_UDP_HDR_TRUNC) ? cap_saddr : '0;
    r.daddr = (code == ERR_OK || code >= ERR_UDP_HDR_TRUNC) ? cap_daddr : '0;
    r.sport = (code == ERR_OK || code >= ERR_UDP_LEN) ? cap_sport : '0;
    r.dport = (code == ERR_OK || code >= ERR_UDP_LEN) ? cap_dport : '0;
    r.pstart = (code == ERR_OK) ? 7'(udp + UDP_HDR_LEN) : '0;
    r.plen = (code == ERR_OK) ? 16'(cap_ulen - UDP_HDR_LEN) : '0;
    expected_results.push_back(r);

    // Clear the model for the next frame
    pos_q = 0;
    cap_link = '0; cap_outer = '0; cap_inner = '0; cap_vihl = '0;
    cap_total = '0; cap_frag = '0; cap_proto = '0; cap_saddr = '0;
    cap_daddr = '0; cap_sport = '0; cap_dport = '0; cap_ulen = '0;
  endtask

  // Write a big-endian field into the frame buffer, dropping bytes past its end
  task automatic put_field(input int at, input int nbytes, input logic [31:0] v);
    for (int k = 0; k < nbytes; k++) begin
      if (at + k < frame_buf.size()) frame_buf[at + k] = v[8 * (nbytes - 1 - k) +: 8];
    end
  endtask

  // Push the frame buffer as byte requests; link type matters on the first byte only
  task automatic queue_frame(input logic [15:0] first_link);
    byte_req_t req;
    for (int i = 0; i < frame_buf.size(); i++) begin
      req.data = frame_buf[i];
      req.link = (i == 0) ? first_link : 16'($urandom);
      req.last = (i == frame_buf.size() - 1);
      pending_bytes.push_back(req);
    end
    frames_queued++;
    bytes_queued += frame_buf.size();
    if (frame_buf.size() > longest_frame) longest_frame = frame_buf.size();
  endtask

  // Build a frame from a header spec over random filler and queue it
  task automatic emit_frame(input frame_spec_t s);
    int net, udp;
    frame_buf = new[s.flen];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    net = is_vlan_tpid(s.outer) ? int'(VLAN_HDR_LEN) : int'(ETH_HDR_LEN);
    udp = net + int'(s.vihl[3:0]) * 4;
    put_field(12, 2, s.outer);
    if (is_vlan_tpid(s.outer)) put_field(16, 2, s.inner);
    // UDP first so that a short IHL cannot clobber the IP header
    put_field(udp, 2, s.sport);
    put_field(udp + 2, 2, s.dport);
    put_field(udp + 4, 2, s.ulen);
    put_field(net, 1, s.vihl);
    put_field(net + 2, 2, s.total);
    put_field(net + 6, 2, s.frag);
    put_field(net + 9, 1, s.proto);
    put_field(net + 12, 4, s.saddr);
    put_field(net + 16, 4, s.daddr);
    queue_frame(s.link);
  endtask

  // Random well-formed UDP frame, optionally tagged, with options and padding
  function automatic frame_spec_t random_udp_spec(input int plen);
    frame_spec_t s;
    int tag, ihl, net;
    tag = $urandom_range(0, 2);
    s.link = LINK_TYPE_ETH;
    s.outer = (tag == 0) ? ETHERTYPE_IPV4 : ((tag == 1) ? TPID_8021Q : TPID_8021AD);
    s.inner = (tag == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    s.vihl = {IP_VERSION4, 4'(ihl)};
    s.ulen = 16'(8 + plen);
    s.total = 16'(ihl * 4 + 8 + plen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0));
    s.frag = {2'($urandom), 14'b0};
    s.proto = IP_PROTO_UDP;
    s.saddr = $urandom;
    s.daddr = $urandom;
    s.sport = 16'($urandom);
    s.dport = 16'($urandom);
    net = (tag == 0) ? 14 : 18;
    s.flen = net + int'(s.total) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
    return s;
  endfunction

  // Sender: bursts of requests separated by random gaps, payload held while stalled
  always @(posedge clk) begin : drive_proc
    byte_req_t nxt;
    logic offer;
    int burst_left, gap_left;
    if (rst) begin
      byte_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!byte_valid || !byte_stall) begin
      if (byte_valid) predict_byte(frame_byte, link_kind, last_byte);
      offer = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 64);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        offer = 1'b1;
        burst_left--;
      end
      byte_valid <= offer;
      if (offer) begin
        frame_byte <= nxt.data;
        link_kind <= nxt.link;
        last_byte <= nxt.last;
      end
    end
  end

  // Receiver: random stall modes, plus one long hold-off to back up the block
  always @(posedge clk) begin : stall_proc
    int recv_cycles, hold_left, mode_left, stall_mode;
    logic hold_done;
    if (rst) begin
      result_stall <= 1'b0;
      recv_cycles = 0;
      hold_left = 0;
      mode_left = 0;
      stall_mode = 0;
      hold_done = 1'b0;
    end else begin
      recv_cycles++;
      if (!hold_done && recv_cycles == HOLD_START) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_proc
    parse_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: error_code %0d", error_code);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("packet_ok", want.ok, packet_ok);
        check_field("error_code", want.code, error_code);
        check_field("source_address", want.saddr, source_address);
        check_field("dest_address", want.daddr, dest_address);
        check_field("source_port", want.sport, source_port);
        check_field("dest_port", want.dport, dest_port);
        check_field("payload_start", want.pstart, payload_start);
        check_field("payload_bytes", want.plen, payload_bytes);
        code_hits[want.code]++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stim_proc
    frame_spec_t fs;
    int rand_bytes, hl, codes_seen;
    foreach (code_hits[i]) code_hits[i] = 0;

    // Single-byte frames: all-ones byte with a non-Ethernet link, then all-zero Ethernet
    frame_buf = new[1];
    frame_buf[0] = 8'hFF;
    queue_frame(16'hFFFF);
    frame_buf[0] = 8'h00;
    queue_frame(LINK_TYPE_ETH);
    // Ethernet header cut one byte short
    fs = random_udp_spec(0);
    fs.outer = ETHERTYPE_IPV4;
    fs.flen = 13;
    emit_frame(fs);
    // Tag present but cut inside it
    fs = random_udp_spec(0);
    fs.outer = TPID_8021Q;
    fs.flen = 17;
    emit_frame(fs);
    // Tagged frame carrying something other than IPv4
    fs = random_udp_spec(4);
    fs.outer = TPID_8021AD;
    fs.inner = 16'h86DD;
    emit_frame(fs);
    // Smallest good frame, untagged, no payload
    fs = random_udp_spec(0);
    fs.outer = ETHERTYPE_IPV4;
    fs.vihl = 8'h45;
    fs.total = 16'd28;
    fs.flen = 42;
    emit_frame(fs);
    // Deepest payload offset: outer tag plus full IP options
    fs = random_udp_spec(0);
    fs.outer = TPID_8021AD;
    fs.inner = ETHERTYPE_IPV4;
    fs.vihl = 8'h4F;
    fs.total = 16'd68;
    fs.flen = 86;
    emit_frame(fs);
    // IHL of zero puts the UDP fields on top of the IP header
    fs = random_udp_spec(6);
    fs.vihl = 8'h40;
    emit_frame(fs);

    // Random part: valid frames, frames with one damaged header field or a cut length, and noise
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      fs = random_udp_spec(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24));
      hl = int'(fs.vihl[3:0]) * 4;
      case ($urandom_range(0, 14))
        5: fs.link = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(2, 65535));
        6: fs.flen = $urandom_range(1, fs.flen - 1);
        7: begin
          if (is_vlan_tpid(fs.outer)) fs.inner = 16'($urandom);
          else fs.outer = 16'($urandom);
        end
        8: fs.vihl[7:4] = 4'($urandom_range(5, 19));
        9: fs.vihl[3:0] = 4'($urandom_range(0, 4));
        10: fs.total = 16'($urandom_range(0, hl + 7));
        11: fs.frag[13:0] = 14'($urandom_range(1, 16'h3FFF));
        12: fs.proto = 8'($urandom_range(18, 273));
        13: begin
          if ($urandom_range(0, 1) == 0) fs.ulen = 16'($urandom_range(0, 7));
          else fs.ulen = 16'(int'(fs.total) - hl + $urandom_range(1, 8));
        end
        14: begin
          // Noise: random bytes of random length
          frame_buf = new[$urandom_range(1, 60)];
          foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
          fs.flen = 0;
          queue_frame(($urandom_range(0, 1) == 0) ? LINK_TYPE_ETH : 16'($urandom));
          rand_bytes += frame_buf.size();
        end
        default: ;
      endcase
      if (fs.flen > 0) begin
        emit_frame(fs);
        rand_bytes += fs.flen;
      end
    end

    // Drain: everything sent, every result back, then a quiet tail
    while (rst || pending_bytes.size() > 0 || byte_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    codes_seen = 0;
    foreach (code_hits[i]) if (code_hits[i] > 0) codes_seen++;
    $display("Ran %0d frames (%0d bytes, longest %0d); %0d results checked, %0d of 16 codes hit.",
             frames_queued, bytes_queued, longest_frame, results_checked, codes_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hold reset at the start, then release it
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/udp_hp_pkg.sv
hdl/udp_hp_front.sv
hdl/udp_hp_queue.sv
hdl/udp_hp_back.sv
hdl/udp_ipv4_header_parser.sv
tb/sv/tb.sv
